FILE: rtl/core/cfm_pkg.sv
// Shared constants, types and codes of the cassette FSK byte modulator.
package cfm_pkg;

	// counter and field widths
	localparam int COUNT_WIDTH = 32;
	localparam int RATE_W      = 17;
	localparam int BAUD_W      = 12;
	localparam int LEVEL_W     = 16;
	localparam int RUN_W       = 6;
	localparam int QDIV_W      = BAUD_W + 2;
	localparam int STEP_W      = RATE_W + 1;
	localparam int RUNSUM_W    = STEP_W + 1;
	localparam int QTR_W       = 2;
	localparam int DIV_STEP_W  = $clog2(COUNT_WIDTH);

	// byte frame: one start cell, eight data cells, two stop cells
	localparam int FRAME_CELLS = 11;
	localparam int CELL_CNT_W  = $clog2(FRAME_CELLS + 1);

	// request queue between front and back
	localparam int FIFO_DEPTH  = 2;
	localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

	// configuration port
	localparam int CFG_ADDR_W  = 4;
	localparam int CFG_DATA_W  = 32;

	// register indexes
	typedef enum logic [1:0] {
		REG_AUDIO_RATE  = 2'd0,
		REG_BAUD_RATE   = 2'd1,
		REG_LOW_LEVEL   = 2'd2,
		REG_HIGH_LEVEL  = 2'd3
	} reg_idx_t;

	// input modes
	localparam logic MODE_DATA   = 1'b0;
	localparam logic MODE_LEADER = 1'b1;

	typedef struct packed {
		logic [RATE_W-1:0]         audio_rate;
		logic [BAUD_W-1:0]         baud_rate;
		logic signed [LEVEL_W-1:0] low_level;
		logic signed [LEVEL_W-1:0] high_level;
	} cfg_t;

	// one queued request: cell bits LSB first and the number of cells
	typedef struct packed {
		logic [FRAME_CELLS-1:0] pattern;
		logic [CELL_CNT_W-1:0]  cells;
	} fr_entry_t;

	typedef struct packed {
		logic                   start;
		logic [COUNT_WIDTH-1:0] dividend;
		logic [QDIV_W-1:0]      divisor;
	} div_req_t;

	typedef struct packed {
		logic                   done;
		logic [COUNT_WIDTH-1:0] quotient;
		logic [QDIV_W-1:0]      remainder;
	} div_rsp_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_DIV_GO,
		BK_DIV_WAIT,
		BK_RUN,
		BK_FLUSH
	} back_state_t;

	// divider passes that rebuild the cell phase after a rate change
	typedef enum logic [1:0] {
		PASS_M,
		PASS_RM,
		PASS_R,
		PASS_Q
	} div_pass_t;

endpackage

FILE: rtl/core/cfm_front.sv
// Front end: accepts requests, frames them into cell patterns and queues them.
module cfm_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 mode,
	input  logic [7:0]           data_byte,
	output logic                 q_valid,
	output cfm_pkg::fr_entry_t   q_entry,
	input  logic                 q_pop
);
	import cfm_pkg::*;

	fr_entry_t              entry_q [FIFO_DEPTH];
	fr_entry_t              framed;
	logic [FIFO_PTR_W-1:0]  wr_ptr_q;
	logic [FIFO_PTR_W-1:0]  rd_ptr_q;
	logic [FIFO_CNT_W-1:0]  cnt_q;
	logic                   push;
	logic                   pop;

	// frame the request: leader is one 1 cell, data is start, byte, two stops
	always_comb begin
		if (mode == MODE_LEADER) begin
			framed.pattern = FRAME_CELLS'(1);
			framed.cells   = CELL_CNT_W'(1);
		end else begin
			framed.pattern = {2'b11, data_byte, 1'b0};
			framed.cells   = CELL_CNT_W'(FRAME_CELLS);
		end
	end

	assign in_ready = (cnt_q != FIFO_CNT_W'(FIFO_DEPTH));
	assign push     = in_valid && in_ready;
	assign q_valid  = (cnt_q != '0);
	assign pop      = q_pop && q_valid;
	assign q_entry  = entry_q[rd_ptr_q];

	// advance queue pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
			if (pop)  rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
			if (push && !pop)      cnt_q <= cnt_q + FIFO_CNT_W'(1);
			else if (!push && pop) cnt_q <= cnt_q - FIFO_CNT_W'(1);
		end
	end

	// store the framed request
	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= framed;
	end

endmodule

FILE: rtl/core/cfm_divider.sv
// Shared restoring divider, one quotient bit per cycle.
module cfm_divider (
	input  logic               clk,
	input  logic               arst_n,
	input  cfm_pkg::div_req_t  req,
	output cfm_pkg::div_rsp_t  rsp
);
	import cfm_pkg::*;

	logic                   busy_q;
	logic                   done_q;
	logic [DIV_STEP_W-1:0]  step_q;
	logic [COUNT_WIDTH-1:0] quo_q;
	logic [QDIV_W-1:0]      rem_q;
	logic [QDIV_W-1:0]      dvs_q;
	logic [QDIV_W:0]        trial;
	logic [QDIV_W:0]        diff;
	logic                   ge;

	// shift in the next dividend bit and try the subtraction
	assign trial = {rem_q, quo_q[COUNT_WIDTH-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign ge    = (trial >= {1'b0, dvs_q});

	// sequence the steps; a new start restarts at once
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= DIV_STEP_W'(COUNT_WIDTH - 1);
		end else if (busy_q) begin
			done_q <= (step_q == '0);
			busy_q <= (step_q != '0);
			step_q <= step_q - DIV_STEP_W'(1);
		end else begin
			done_q <= 1'b0;
		end
	end

	// quotient shares the dividend register
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[COUNT_WIDTH-2:0], ge};
			rem_q <= ge ? diff[QDIV_W-1:0] : trial[QDIV_W-1:0];
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

endmodule

FILE: rtl/core/cfm_back.sv
// Back end: walks cells quarter by quarter and emits level runs.
module cfm_back (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  cfm_pkg::cfg_t                        cfg,
	input  logic                                 cfg_change,
	input  logic                                 q_valid,
	input  cfm_pkg::fr_entry_t                   q_entry,
	output logic                                 q_pop,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [cfm_pkg::LEVEL_W-1:0]   level,
	output logic [cfm_pkg::RUN_W-1:0]            run_length,
	output logic                                 last
);
	import cfm_pkg::*;

	back_state_t state_q, state_d;
	div_pass_t   pass_q;
	div_req_t    div_req;
	div_rsp_t    div_rsp;

	logic                   need_rc_q;
	logic [COUNT_WIDTH-1:0] cell_index_q;
	logic [COUNT_WIDTH-1:0] sample_pos_q;
	logic [BAUD_W-1:0]      m_q;
	logic [BAUD_W-1:0]      r_q;
	logic [BAUD_W-1:0]      rm_q;
	logic [RATE_W-1:0]      rq_q;
	logic [QDIV_W-1:0]      rr_q;
	logic [QDIV_W-1:0]      rem_q;
	logic [STEP_W-1:0]      acc_q;
	logic [QTR_W-1:0]       qtr_q;
	logic [FRAME_CELLS-1:0] pat_q;
	logic [CELL_CNT_W-1:0]  cells_q;

	logic                      pend_v_q;
	logic signed [LEVEL_W-1:0] pend_level_q;
	logic [RUN_W-1:0]          pend_len_q;

	logic                      out_v_q;
	logic signed [LEVEL_W-1:0] out_level_q;
	logic [RUN_W-1:0]          out_len_q;
	logic                      out_last_q;

	logic [BAUD_W-1:0]       baud;
	logic [QDIV_W-1:0]       dvs4;
	logic [QDIV_W:0]         start_sum;
	logic [QDIV_W-1:0]       start_red;
	logic [QDIV_W-1:0]       rem_base;
	logic [QDIV_W:0]         step_sum;
	logic                    carry;
	logic [QDIV_W-1:0]       rem_nxt;
	logic [STEP_W-1:0]       d;
	logic                    run_emit;
	logic [RUNSUM_W-1:0]     run_len;
	logic                    run_nz;
	logic [RUN_W-1:0]        run_sat;
	logic signed [LEVEL_W-1:0] run_level;
	logic [BAUD_W:0]         m_inc;
	logic [BAUD_W:0]         r_add;
	logic [BAUD_W-1:0]       m_nxt;
	logic [BAUD_W-1:0]       r_nxt;
	logic [2*BAUD_W-1:0]     prod;

	logic out_free;
	logic step;
	logic take_run;
	logic push_out;
	logic push_last;

	cfm_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// zero baud counts as one; quarter divisor is four times it
	assign baud = (cfg.baud_rate == '0) ? BAUD_W'(1) : cfg.baud_rate;
	assign dvs4 = {baud, 2'b00};

	// quarter step: remainder walk against 4*baud
	always_comb begin
		start_sum = {1'b0, r_q, 2'b00} + {2'b00, baud, 1'b0};
		start_red = (start_sum >= {1'b0, dvs4}) ? QDIV_W'(start_sum - {1'b0, dvs4})
		                                        : start_sum[QDIV_W-1:0];
		rem_base  = (qtr_q == '0) ? start_red : rem_q;
		step_sum  = {1'b0, rem_base} + {1'b0, rr_q};
		carry     = (step_sum >= {1'b0, dvs4});
		rem_nxt   = carry ? QDIV_W'(step_sum - {1'b0, dvs4}) : step_sum[QDIV_W-1:0];
		d         = {1'b0, rq_q} + STEP_W'(carry);
		run_emit  = pat_q[0] || qtr_q[0];
		run_len   = {1'b0, acc_q} + {1'b0, d};
		run_nz    = (run_len != '0);
		run_sat   = (run_len > RUNSUM_W'({RUN_W{1'b1}})) ? {RUN_W{1'b1}} : run_len[RUN_W-1:0];
		if (pat_q[0]) run_level = qtr_q[0] ? cfg.high_level : cfg.low_level;
		else          run_level = qtr_q[1] ? cfg.high_level : cfg.low_level;
	end

	// cell phase: cell index mod baud and its sample remainder
	always_comb begin
		m_inc = {1'b0, m_q} + (BAUD_W+1)'(1);
		m_nxt = (m_inc == {1'b0, baud}) ? '0 : m_inc[BAUD_W-1:0];
		r_add = {1'b0, r_q} + {1'b0, rm_q};
		r_nxt = (r_add >= {1'b0, baud}) ? BAUD_W'(r_add - {1'b0, baud}) : r_add[BAUD_W-1:0];
		prod  = m_q * rm_q;
	end

	assign out_free = !out_v_q || out_ready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (need_rc_q)    state_d = BK_DIV_GO;
				else if (q_valid) state_d = BK_RUN;
			end
			BK_DIV_GO: state_d = BK_DIV_WAIT;
			BK_DIV_WAIT: begin
				if (need_rc_q)         state_d = BK_DIV_GO;
				else if (div_rsp.done) state_d = (pass_q == PASS_Q) ? BK_IDLE : BK_DIV_GO;
			end
			BK_RUN: begin
				if (step && qtr_q == '1 && cells_q == CELL_CNT_W'(1)) state_d = BK_FLUSH;
			end
			BK_FLUSH: begin
				if (!pend_v_q || out_free) state_d = BK_IDLE;
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		q_pop     = 1'b0;
		step      = 1'b0;
		take_run  = 1'b0;
		push_out  = 1'b0;
		push_last = 1'b0;
		div_req.start    = 1'b0;
		div_req.dividend = '0;
		div_req.divisor  = {2'b00, baud};
		unique case (pass_q)
			PASS_M:  div_req.dividend = cell_index_q;
			PASS_RM: div_req.dividend = COUNT_WIDTH'(cfg.audio_rate);
			PASS_R:  div_req.dividend = COUNT_WIDTH'(prod);
			PASS_Q: begin
				div_req.dividend = COUNT_WIDTH'(cfg.audio_rate);
				div_req.divisor  = dvs4;
			end
			default: div_req.dividend = '0;
		endcase
		unique case (state_q)
			BK_IDLE:     q_pop = !need_rc_q && q_valid;
			BK_DIV_GO:   div_req.start = 1'b1;
			BK_DIV_WAIT: ;
			BK_RUN: begin
				step     = !(run_emit && run_nz && pend_v_q && !out_free);
				take_run = step && run_emit && run_nz;
				push_out = take_run && pend_v_q;
			end
			BK_FLUSH: begin
				push_out  = pend_v_q && out_free;
				push_last = 1'b1;
			end
			default: ;
		endcase
	end

	// state, phase rebuild requests and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= BK_IDLE;
			pass_q       <= PASS_M;
			need_rc_q    <= 1'b1;
			cell_index_q <= '0;
			sample_pos_q <= '0;
			pend_v_q     <= 1'b0;
			out_v_q      <= 1'b0;
		end else begin
			state_q   <= state_d;
			need_rc_q <= cfg_change ||
			             (need_rc_q && !(state_q == BK_DIV_GO && pass_q == PASS_M));
			// restart or advance the divider passes
			if (state_q == BK_IDLE || (state_q == BK_DIV_WAIT && need_rc_q))
				pass_q <= PASS_M;
			else if (state_q == BK_DIV_WAIT && div_rsp.done)
				pass_q <= div_pass_t'(pass_q + 2'd1);
			// advance position counters once per quarter and per cell
			if (step) begin
				sample_pos_q <= sample_pos_q + COUNT_WIDTH'(d);
				if (qtr_q == '1) cell_index_q <= cell_index_q + COUNT_WIDTH'(1);
			end
			// hold one run back so the last one can be marked
			if (take_run)      pend_v_q <= 1'b1;
			else if (push_out) pend_v_q <= 1'b0;
			// output register
			if (push_out)       out_v_q <= 1'b1;
			else if (out_ready) out_v_q <= 1'b0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == BK_DIV_WAIT && div_rsp.done) begin
			unique case (pass_q)
				PASS_M:  m_q  <= div_rsp.remainder[BAUD_W-1:0];
				PASS_RM: rm_q <= div_rsp.remainder[BAUD_W-1:0];
				PASS_R:  r_q  <= div_rsp.remainder[BAUD_W-1:0];
				PASS_Q: begin
					rq_q <= div_rsp.quotient[RATE_W-1:0];
					rr_q <= div_rsp.remainder;
				end
				default: ;
			endcase
		end
		if (q_pop) begin
			pat_q   <= q_entry.pattern;
			cells_q <= q_entry.cells;
			qtr_q   <= '0;
			acc_q   <= '0;
		end else if (step) begin
			rem_q <= rem_nxt;
			qtr_q <= qtr_q + QTR_W'(1);
			acc_q <= run_emit ? '0 : d;
			if (qtr_q == '1) begin
				pat_q   <= pat_q >> 1;
				cells_q <= cells_q - CELL_CNT_W'(1);
				// drop the phase back to cell zero when the index wraps
				if (&cell_index_q) begin
					m_q <= '0;
					r_q <= '0;
				end else begin
					m_q <= m_nxt;
					r_q <= r_nxt;
				end
			end
		end
		if (take_run) begin
			pend_level_q <= run_level;
			pend_len_q   <= run_sat;
		end
		if (push_out) begin
			out_level_q <= pend_level_q;
			out_len_q   <= pend_len_q;
			out_last_q  <= push_last;
		end
	end

	assign out_valid  = out_v_q;
	assign level      = out_level_q;
	assign run_length = out_len_q;
	assign last       = out_last_q;

endmodule

FILE: rtl/core/cassette_fsk_byte_modulator.sv
// Top level of the cassette FSK byte modulator: register port, front and back.
// With the back idle, the first run of a request passes the front queue, the held run and
// the output register before it shows, and shows later when leading runs are empty.
// The back walks each cell quarter by quarter and passes an idle and a flush state between
// requests, so it takes the next request only after the flush; it waits while the output stalls.
// Reset and every audio_rate or baud_rate write start a phase rebuild of four divider passes
// before the next request is worked.
module cassette_fsk_byte_modulator (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 mode,
	input  logic [7:0]                           data_byte,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [cfm_pkg::LEVEL_W-1:0]   level,
	output logic [cfm_pkg::RUN_W-1:0]            run_length,
	output logic                                 last,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [cfm_pkg::CFG_ADDR_W-1:0]       paddr,
	input  logic [cfm_pkg::CFG_DATA_W-1:0]       pwdata,
	output logic [cfm_pkg::CFG_DATA_W-1:0]       prdata,
	output logic                                 pready
);
	import cfm_pkg::*;

	cfg_t      cfg_q;
	reg_idx_t  idx;
	logic      wr;
	logic      cfg_change;
	logic      q_valid;
	logic      q_pop;
	fr_entry_t q_entry;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;
	assign idx    = reg_idx_t'(paddr[3:2]);

	// rate registers change the cell phase
	assign cfg_change = wr && (idx == REG_AUDIO_RATE || idx == REG_BAUD_RATE);

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.audio_rate  <= RATE_W'(44100);
			cfg_q.baud_rate   <= BAUD_W'(1200);
			cfg_q.low_level   <= LEVEL_W'(0);
			cfg_q.high_level  <= LEVEL_W'(255);
		end else if (wr) begin
			unique case (idx)
				REG_AUDIO_RATE:  cfg_q.audio_rate  <= pwdata[RATE_W-1:0];
				REG_BAUD_RATE:   cfg_q.baud_rate   <= pwdata[BAUD_W-1:0];
				REG_LOW_LEVEL:   cfg_q.low_level   <= pwdata[LEVEL_W-1:0];
				REG_HIGH_LEVEL:  cfg_q.high_level  <= pwdata[LEVEL_W-1:0];
				default: ;
			endcase
		end
	end

	// register reads
	always_comb begin
		unique case (idx)
			REG_AUDIO_RATE:  prdata = CFG_DATA_W'(cfg_q.audio_rate);
			REG_BAUD_RATE:   prdata = CFG_DATA_W'(cfg_q.baud_rate);
			REG_LOW_LEVEL:   prdata = CFG_DATA_W'(unsigned'(cfg_q.low_level));
			REG_HIGH_LEVEL:  prdata = CFG_DATA_W'(unsigned'(cfg_q.high_level));
			default:         prdata = '0;
		endcase
	end

	cfm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.data_byte (data_byte),
		.q_valid   (q_valid),
		.q_entry   (q_entry),
		.q_pop     (q_pop)
	);

	cfm_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.cfg_change (cfg_change),
		.q_valid    (q_valid),
		.q_entry    (q_entry),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.level      (level),
		.run_length (run_length),
		.last       (last)
	);

endmodule

FILE: rtl/core/cfm_checker.sv
// Port-level checks of the cassette FSK byte modulator, bound to the top level.
module cfm_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 in_valid,
	input logic                                 in_ready,
	input logic                                 mode,
	input logic [7:0]                           data_byte,
	input logic                                 out_valid,
	input logic                                 out_ready,
	input logic signed [cfm_pkg::LEVEL_W-1:0]   level,
	input logic [cfm_pkg::RUN_W-1:0]            run_length,
	input logic                                 last,
	input logic                                 psel,
	input logic                                 penable,
	input logic                                 pwrite,
	input logic [cfm_pkg::CFG_ADDR_W-1:0]       paddr,
	input logic [cfm_pkg::CFG_DATA_W-1:0]       pwdata,
	input logic [cfm_pkg::CFG_DATA_W-1:0]       prdata,
	input logic                                 pready
);
	import cfm_pkg::*;

	// a stalled run holds its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(level) && $stable(run_length)
		&& $stable(last))
		else $error("run changed while stalled");

	// empty runs are never shown
	a_run_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> run_length != '0)
		else $error("zero length run emitted");

	// an audio rate write reads back at its own width
	a_rate_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && paddr[3:2] == REG_AUDIO_RATE
		|=> !psel || !penable || pwrite || paddr[3:2] != REG_AUDIO_RATE
		|| prdata == CFG_DATA_W'($past(pwdata[RATE_W-1:0])))
		else $error("audio rate readback mismatch");

	// baud_rate reads carry no bits above its width
	a_baud_width: assert property (@(posedge clk) disable iff (!arst_n)
		psel && !pwrite && paddr[3:2] == REG_BAUD_RATE |-> prdata[CFG_DATA_W-1:BAUD_W] == '0)
		else $error("baud_rate read has stray bits");

endmodule

bind cassette_fsk_byte_modulator cfm_checker u_cfm_checker (.*);
